@@ src/whb_pkg.sv @@
// Shared constants, payload types and controller/datapath command and status
// structs for the weighted histogram bin counter. No dependencies.
package whb_pkg;

  localparam int BIN_COUNT  = 64;
  localparam int TOTAL_W    = 48;
  localparam int BIN_W      = $clog2(BIN_COUNT);
  localparam int CNT_W      = $clog2(BIN_COUNT + 1);
  localparam int SAMPLE_W   = 32;
  localparam int WEIGHT_W   = 32;
  localparam int MINB_W     = 7;
  localparam int IDX_OUT_W  = 6;
  // adder width: wide enough that cur + weight never wraps
  localparam int SUM_W      = ((TOTAL_W > WEIGHT_W) ? TOTAL_W : WEIGHT_W) + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BINS      = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic signed [WEIGHT_W-1:0] sample_weight;
    logic                       last_sample;
  } sample_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]      bin_index;
    logic signed [TOTAL_W-1:0] bin_total;
    logic                      last_bin;
    logic                      error_seen;
  } result_t;

  typedef struct packed {
    logic capture;    // latch sample, read its bin
    logic update;     // write back saturated sum
    logic rd_setup;   // latch bin count, zero read counter
    logic rd_issue;   // read bin at read counter
    logic out_load;   // load output register
    logic k_inc;      // advance read counter
    logic clear_set;  // drop the set: bins, largest, any
  } dp_cmd_t;

  typedef struct packed {
    logic last;       // held sample ends the set
    logic nbins_zero; // readout would report nothing
    logic rd_last;    // read counter is at the final bin
    logic out_free;   // output register can take a result
  } dp_sts_t;

endpackage

@@ src/whb_if.sv @@
// Channel interfaces: sample input, bin result output, register writes.
// Depends on whb_pkg.
interface whb_sample_if import whb_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface whb_result_if import whb_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface whb_cfg_if import whb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ src/whb_ctrl.sv @@
// Controller state machine: sequences sample update and bin readout.
// Depends on whb_pkg.
module whb_ctrl import whb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_UPDATE   = 5'b00010,
    S_RD_START = 5'b00100,
    S_RD_ADDR  = 5'b01000,
    S_RD_DATA  = 5'b10000
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = sts.last ? S_RD_START : S_IDLE;
      end
      S_RD_START: begin
        cmd.rd_setup = 1'b1;
        if (sts.nbins_zero) begin
          cmd.clear_set = 1'b1;
          state_next    = S_IDLE;
        end else begin
          state_next = S_RD_ADDR;
        end
      end
      S_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.rd_last) begin
            cmd.clear_set = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.k_inc  = 1'b1;
            state_next = S_RD_ADDR;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/whb_datapath.sv @@
// Datapath: bin memory with per-bin valid flags, saturating adder,
// largest-sample tracking, readout counter, output register, config regs.
// Depends on whb_pkg.
module whb_datapath import whb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  sample_t               sample,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output result_t               result
);

  logic [TOTAL_W-1:0] mem [BIN_COUNT];
  logic [BIN_COUNT-1:0] bin_valid;

  logic               weighted_mode;
  logic [MINB_W-1:0]  min_bins;

  logic [BIN_W-1:0]   s_bin;
  logic               s_ok;
  logic [WEIGHT_W-1:0] s_weight;
  logic               s_last;
  logic               s_mode;

  logic [BIN_W-1:0]   largest;
  logic               any_sample;
  logic               error_flag;
  logic [CNT_W-1:0]   nbins;
  logic [BIN_W-1:0]   rd_cnt;
  logic [TOTAL_W-1:0] rd_data;
  logic               rd_hit;

  logic               in_ok;
  logic [BIN_W-1:0]   rd_addr;
  logic               rd_en;
  logic               wr_en;
  logic [TOTAL_W-1:0] cur;
  logic [SUM_W-1:0]   cur_ext;
  logic [SUM_W-1:0]   addend;
  logic [SUM_W-1:0]   sum;
  logic               ovf;
  logic [TOTAL_W-1:0] sum_sat;
  logic [CNT_W-1:0]   cand;
  logic [MINB_W-1:0]  cand_m;
  logic [MINB_W-1:0]  nb_m;
  logic [CNT_W-1:0]   nb_next;

  assign in_ok = (sample.sample_value >= 0) &&
                 (sample.sample_value < SAMPLE_W'(BIN_COUNT));
  assign rd_addr = cmd.capture ? sample.sample_value[BIN_W-1:0] : rd_cnt;
  assign rd_en   = (cmd.capture && in_ok) || cmd.rd_issue;
  assign wr_en   = cmd.update && s_ok;

  // saturating accumulate; the extra top bits catch the overflow
  assign cur     = rd_hit ? rd_data : '0;
  assign cur_ext = {{(SUM_W-TOTAL_W){cur[TOTAL_W-1]}}, cur};
  assign addend  = s_mode ? {{(SUM_W-WEIGHT_W){s_weight[WEIGHT_W-1]}}, s_weight}
                          : SUM_W'(1);
  assign sum     = cur_ext + addend;
  assign ovf     = (sum[SUM_W-1:TOTAL_W-1] != '0) && (sum[SUM_W-1:TOTAL_W-1] != '1);
  assign sum_sat = ovf ? (sum[SUM_W-1] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                       : {1'b0, {(TOTAL_W-1){1'b1}}})
                       : sum[TOTAL_W-1:0];

  // bins to report: max(largest+1, min_bins), capped at the store size
  assign cand    = any_sample ? (CNT_W'(largest) + CNT_W'(1)) : '0;
  assign cand_m  = MINB_W'(cand);
  assign nb_m    = (min_bins > cand_m) ? min_bins : cand_m;
  assign nb_next = (nb_m > MINB_W'(BIN_COUNT)) ? CNT_W'(BIN_COUNT) : CNT_W'(nb_m);

  assign sts.last       = s_last;
  assign sts.nbins_zero = (nb_next == '0);
  assign sts.rd_last    = ((CNT_W'(rd_cnt) + CNT_W'(1)) == nbins);
  assign sts.out_free   = !out_valid || out_ready;

  // bin memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s_bin] <= sum_sat;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // sample payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      s_bin    <= sample.sample_value[BIN_W-1:0];
      s_weight <= sample.sample_weight;
      s_mode   <= weighted_mode;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.bin_index  <= IDX_OUT_W'(rd_cnt);
      result.bin_total  <= rd_hit ? rd_data : '0;
      result.last_bin   <= sts.rd_last;
      result.error_seen <= error_flag;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      weighted_mode <= 1'b0;
      min_bins      <= '0;
      s_ok          <= 1'b0;
      s_last        <= 1'b0;
      bin_valid     <= '0;
      largest       <= '0;
      any_sample    <= 1'b0;
      error_flag    <= 1'b0;
      nbins         <= '0;
      rd_cnt        <= '0;
      rd_hit        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WEIGHTED_MODE: weighted_mode <= cfg_wdata[0];
          CFG_MIN_BINS:      min_bins      <= cfg_wdata[MINB_W-1:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        s_ok   <= in_ok;
        s_last <= sample.last_sample;
      end
      if (rd_en) begin
        rd_hit <= bin_valid[rd_addr];
      end
      if (cmd.update) begin
        if (s_ok) begin
          bin_valid[s_bin] <= 1'b1;
          any_sample       <= 1'b1;
          if (!any_sample || (s_bin > largest)) begin
            largest <= s_bin;
          end
        end else begin
          error_flag <= 1'b1;
        end
      end
      if (cmd.rd_setup) begin
        nbins  <= nb_next;
        rd_cnt <= '0;
      end else if (cmd.k_inc) begin
        rd_cnt <= rd_cnt + BIN_W'(1);
      end
      if (cmd.clear_set) begin
        bin_valid  <= '0;
        any_sample <= 1'b0;
        largest    <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/weighted_histogram_bincount.sv @@
// Weighted histogram bin counter. A sample is accepted, then its bin is updated;
// the next sample can be taken on the cycle after the update unless a readout
// follows. Readout after a last sample: a setup step, then per bin a memory read
// and an output load that waits while the output register is full. Sync active-high
// reset clears control state and marks all bins empty through per-bin valid flags.
module weighted_histogram_bincount import whb_pkg::*; (
  input logic          clk,
  input logic          rst,
  whb_sample_if.sink   sample_in,
  whb_result_if.source bin_out,
  whb_cfg_if.sink      cfg
);

  // Structure:
  //   whb_ctrl     - one-hot FSM: IDLE -> UPDATE -> (RD_START -> RD_ADDR <-> RD_DATA)
  //   whb_datapath - 64 x 48 bin memory, valid flags, saturating adder,
  //                  largest-bin tracker, read counter, output register.
  // A sample transaction reads its bin in the accept cycle; the next cycle
  // writes back the saturated sum. Only one sample is in flight, so no
  // read/write forwarding is needed.
  // The output register decouples readout from the downstream consumer: a
  // new sample can be accepted while the final result still waits.

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;
  logic    in_fire;
  logic    cfg_fire;
  logic    out_valid;
  result_t result;

  assign in_fire  = sample_in.valid && in_ready;
  assign cfg_fire = cfg.valid && cfg.ready;

  assign sample_in.ready = in_ready;
  assign cfg.ready       = 1'b1;  // register writes are always accepted
  assign bin_out.valid   = out_valid;
  assign bin_out.data    = result;

  whb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  whb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_in.data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_fire),
    .cfg_index (cfg.index),
    .cfg_wdata (cfg.wdata),
    .out_ready (bin_out.ready),
    .out_valid (out_valid),
    .result    (result)
  );

`ifndef SYNTH
  // one sample at a time: the cycle after a transaction is the update cycle
  a_single_sample: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !sample_in.ready)
    else $error("sample accepted during update");

  // output register is never overwritten while a result is still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // sticky error flag: once reported, later results keep reporting it
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (bin_out.valid && bin_out.data.error_seen) |=>
      (!bin_out.valid || bin_out.data.error_seen))
    else $error("error flag dropped");
`endif

endmodule

@@ dv/tb.sv @@
// Testbench for weighted_histogram_bincount: directed and random sample sets are
// checked, one bin at a time, against an in-bench histogram model.
// Depends on whb_pkg, the whb_*_if interfaces and the block itself.
module tb;
  import whb_pkg::*;

  // run bounds
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 360;
  // cycles the block may still be busy after the last bin left
  // (bin update, readout setup, an empty readout)
  localparam int unsigned QUIET_CYCLES = 8;
  // heavy-weight adds per bin in the full-rate test
  localparam int unsigned HEAVY_REPEATS = 16;
  localparam int unsigned MAX_REPORTS  = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  whb_sample_if sample_ch ();
  whb_result_if bin_ch ();
  whb_cfg_if    cfg_ch ();

  weighted_histogram_bincount DUT (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_ch),
    .bin_out   (bin_ch),
    .cfg       (cfg_ch)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Histogram model: shadow copy of the bins, set tracking and registers
  // ---------------------------------------------------------------------------
  logic signed [TOTAL_W-1:0] shadow_bins [BIN_COUNT];
  logic [BIN_W-1:0]          top_bin;
  bit                        seen_valid;
  bit                        err_sticky;
  bit                        mode_weighted;
  logic [MINB_W-1:0]         min_bins_cfg;

  // bins still owed by the block, oldest first
  result_t     expected_bins [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // sender burst state
  bit          gaps_on    = 1'b1;
  int unsigned burst_left = 0;

  // clamp a Q16.16 or count sum into the signed 48-bit total range
  function automatic logic signed [TOTAL_W-1:0] saturating_add(
    input logic signed [TOTAL_W-1:0] acc,
    input longint                    addend
  );
    longint sum;
    longint hi;
    longint lo;
    hi  = (longint'(1) <<< (TOTAL_W - 1)) - 1;
    lo  = -hi - 1;
    sum = longint'(acc) + addend;
    if (sum > hi) begin
      sum = hi;
    end else if (sum < lo) begin
      sum = lo;
    end
    return sum[TOTAL_W-1:0];
  endfunction

  // Fold one accepted sample into the model. On a last sample, queue the
  // readout bins and drop the set (the error flag survives).
  function automatic void tally_sample(input sample_t s);
    logic [BIN_W-1:0] bin_idx;
    int unsigned      span;
    result_t          r;
    if (s.sample_value < 0 || s.sample_value >= BIN_COUNT) begin
      err_sticky = 1'b1;
    end else begin
      bin_idx = s.sample_value[BIN_W-1:0];
      shadow_bins[bin_idx] = saturating_add(shadow_bins[bin_idx],
        mode_weighted ? longint'(s.sample_weight) : longint'(1));
      if (!seen_valid || bin_idx > top_bin) top_bin = bin_idx;
      seen_valid = 1'b1;
    end
    if (s.last_sample) begin
      span = seen_valid ? top_bin + 1 : 0;
      if (min_bins_cfg > span) span = 32'(min_bins_cfg);
      if (span > BIN_COUNT) span = BIN_COUNT;
      for (int k = 0; k < span; k++) begin
        r.bin_index  = k[IDX_OUT_W-1:0];
        r.bin_total  = shadow_bins[k];
        r.last_bin   = (k == span - 1);
        r.error_seen = err_sticky;
        expected_bins.push_back(r);
      end
      for (int k = 0; k < BIN_COUNT; k++) shadow_bins[k] = '0;
      top_bin    = '0;
      seen_valid = 1'b0;
    end
  endfunction

  function automatic sample_t make_sample(input int value, input int weight, input bit last);
    sample_t s;
    s.sample_value  = value;
    s.sample_weight = weight;
    s.last_sample   = last;
    return s;
  endfunction

  function automatic void note_mismatch(input string field, input longint want,
                                        input longint got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every bin transaction is matched against the oldest
  // expectation, field by field. Sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && bin_ch.valid && bin_ch.ready) begin
      if (expected_bins.size() == 0) begin
        note_mismatch("unexpected bin_index", -1, longint'(bin_ch.data.bin_index));
      end else begin
        want = expected_bins.pop_front();
        if (bin_ch.data.bin_index !== want.bin_index)
          note_mismatch("bin_index", longint'(want.bin_index),
                        longint'(bin_ch.data.bin_index));
        if (bin_ch.data.bin_total !== want.bin_total)
          note_mismatch("bin_total", longint'(want.bin_total),
                        longint'(bin_ch.data.bin_total));
        if (bin_ch.data.last_bin !== want.last_bin)
          note_mismatch("last_bin", longint'(want.last_bin),
                        longint'(bin_ch.data.last_bin));
        if (bin_ch.data.error_seen !== want.error_seen)
          note_mismatch("error_seen", longint'(want.error_seen),
                        longint'(bin_ch.data.error_seen));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: runs of always-ready, light stall, heavy stall
  // and strict toggling, each for a random stretch.
  initial begin
    int unsigned phase_left;
    int unsigned stall_style;
    phase_left  = 0;
    stall_style = 0;
    bin_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        stall_style = $urandom_range(0, 3);
        phase_left  = $urandom_range(10, 80);
      end else begin
        phase_left--;
      end
      case (stall_style)
        0: bin_ch.ready <= 1'b1;
        1: bin_ch.ready <= ($urandom_range(0, 3) != 0);
        2: bin_ch.ready <= ($urandom_range(0, 2) == 0);
        default: bin_ch.ready <= ~bin_ch.ready;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All tasks are entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // One sample transaction. valid stays high on return so back-to-back
  // samples do not bubble; bursts end with a random gap.
  task automatic send_sample(input sample_t s);
    if (gaps_on) begin
      if (burst_left == 0) begin
        sample_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= s;
    do @(posedge clk); while (!sample_ch.ready);
    tally_sample(s);
    @(negedge clk);
  endtask

  // Stop sending, wait for every owed bin, then let the pipeline drain.
  task automatic settle_idle();
    sample_ch.valid <= 1'b0;
    while (expected_bins.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Register write transaction, only with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    settle_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_WEIGHTED_MODE) mode_weighted = val[0];
    else min_bins_cfg = val[MINB_W-1:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests. The error flag is sticky, so every clean test runs before the
  // bad-sample test.
  // ---------------------------------------------------------------------------

  // Count mode: extreme bins, repeats, a readout of all 64 and one of one.
  task automatic test_count_mode();
    write_reg(CFG_WEIGHTED_MODE, 7'd0);
    write_reg(CFG_MIN_BINS, 7'd0);
    send_sample(make_sample(0, 32'h7FFF_FFFF, 1'b0));
    send_sample(make_sample(63, 32'h8000_0000, 1'b0));
    send_sample(make_sample(5, 0, 1'b0));
    send_sample(make_sample(5, -1, 1'b0));
    send_sample(make_sample(3, 0, 1'b1));
    send_sample(make_sample(0, 0, 1'b1));
  endtask

  // Weighted mode: extreme weights cancelling and summing in one bin.
  task automatic test_weighted_mode();
    write_reg(CFG_WEIGHTED_MODE, 7'd1);
    send_sample(make_sample(2, 32'h7FFF_FFFF, 1'b0));
    send_sample(make_sample(2, 32'h8000_0000, 1'b0));
    send_sample(make_sample(7, -1, 1'b0));
    send_sample(make_sample(7, 32'h0001_0000, 1'b0));
    send_sample(make_sample(4, 32'h0000_8000, 1'b1));
  endtask

  // Floor on the readout length, including values past the bin count.
  task automatic test_min_bins();
    write_reg(CFG_MIN_BINS, 7'd64);
    send_sample(make_sample(1, 32'h0002_0000, 1'b1));
    write_reg(CFG_MIN_BINS, 7'd127);
    send_sample(make_sample(62, -5, 1'b1));
    write_reg(CFG_MIN_BINS, 7'd65);
    send_sample(make_sample(0, 3, 1'b1));
    write_reg(CFG_MIN_BINS, 7'd10);
    send_sample(make_sample(3, 1, 1'b1));
    write_reg(CFG_MIN_BINS, 7'd0);
    send_sample(make_sample(40, 9, 1'b1));
  endtask

  // Mode flipped in the middle of a set: the earlier Q16.16 add stays as is.
  task automatic test_mode_switch();
    write_reg(CFG_WEIGHTED_MODE, 7'd1);
    send_sample(make_sample(1, 32'h0003_0000, 1'b0));
    write_reg(CFG_WEIGHTED_MODE, 7'd0);
    send_sample(make_sample(1, 32'h0005_0000, 1'b1));
  endtask

  // Pile the heaviest weights of both signs into bins 0 and 1, then step
  // bin 0 back down. Full rate, no gaps.
  task automatic test_full_rate();
    write_reg(CFG_WEIGHTED_MODE, 7'd1);
    write_reg(CFG_MIN_BINS, 7'd0);
    gaps_on = 1'b0;
    for (int unsigned n = 0; n < HEAVY_REPEATS; n++) begin
      send_sample(make_sample(0, 32'h7FFF_FFFF, 1'b0));
      send_sample(make_sample(1, 32'h8000_0000, 1'b0));
    end
    send_sample(make_sample(0, -1, 1'b1));
    gaps_on = 1'b1;
  endtask

  // Out-of-range samples: empty readout, floor-only readout, error sticky.
  task automatic test_bad_samples();
    write_reg(CFG_WEIGHTED_MODE, 7'd0);
    write_reg(CFG_MIN_BINS, 7'd0);
    send_sample(make_sample(-1, 0, 1'b1));            // nothing to report
    write_reg(CFG_MIN_BINS, 7'd3);
    send_sample(make_sample(64, 0, 1'b1));            // three empty bins
    send_sample(make_sample(32'h7FFF_FFFF, 0, 1'b0));
    send_sample(make_sample(32'h8000_0000, 0, 1'b0));
    send_sample(make_sample(4, 0, 1'b0));
    send_sample(make_sample(100, 0, 1'b1));           // last is bad, set still reported
  endtask

  function automatic int pick_value();
    case ($urandom_range(0, 19))
      0, 1:    return 32'h8000_0000 | $urandom();     // negative
      2:       return $urandom_range(64, 32'h7FFF_FFFF);
      3, 4, 5, 6, 7: return $urandom_range(0, BIN_COUNT - 1);
      default: return $urandom_range(0, 15);          // short readouts
    endcase
  endfunction

  function automatic int pick_weight();
    if ($urandom_range(0, 1) != 0) return $urandom();
    return int'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
  endfunction

  // Random sets of random length, with register changes and drain pauses
  // between sets.
  task automatic test_random_sets();
    int unsigned sent;
    int unsigned set_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        write_reg(CFG_WEIGHTED_MODE, 7'($urandom_range(0, 1)));
        case ($urandom_range(0, 5))
          0: write_reg(CFG_MIN_BINS, 7'd0);
          1: write_reg(CFG_MIN_BINS, 7'd64);
          2: write_reg(CFG_MIN_BINS, 7'd127);
          3: write_reg(CFG_MIN_BINS, 7'($urandom_range(0, 127)));
          default: write_reg(CFG_MIN_BINS, 7'($urandom_range(0, 8)));
        endcase
      end else if ($urandom_range(0, 9) == 0) begin
        settle_idle();
      end
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int unsigned n = 1; n <= set_len; n++) begin
        send_sample(make_sample(pick_value(), pick_weight(), n == set_len));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.wdata    = '0;
    for (int k = 0; k < BIN_COUNT; k++) shadow_bins[k] = '0;
    top_bin       = '0;
    seen_valid    = 1'b0;
    err_sticky    = 1'b0;
    mode_weighted = 1'b0;
    min_bins_cfg  = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_count_mode();
    test_weighted_mode();
    test_min_bins();
    test_mode_switch();
    test_full_rate();
    test_bad_samples();
    test_random_sets();

    settle_idle();
    if (mismatch_count == 0 && expected_bins.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
